@@ rtl/ipq_pkg.sv @@
package ipq_pkg;

    localparam int ID_W     = 6;
    localparam int AMT_W    = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // ids at or above this cannot be addressed by the entry_id field
    localparam int MAX_SLOTS = 1 << ID_W;

    localparam int ENTRY_COUNT_DEF = 64;
    localparam int LEVEL_BITS_DEF  = 16;
    localparam int STAMP_BITS_DEF  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_INCREASE = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_PRESENT = 2'd3
    } status_t;

    typedef struct packed {
        logic load_in;
        logic status_load;
        logic do_insert;
        logic do_remove;
        logic rd_entry;
        logic do_inc_wr;
        logic scan_clear;
        logic scan_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic in_range;
        logic present;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ rtl/ipq_ram.sv @@
module ipq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ipq_ctrl.sv @@
module ipq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  ipq_pkg::ctrl_sts_t sts,
    output ipq_pkg::ctrl_cmd_t ctl
);

    import ipq_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        INC_WAIT,
        SCAN,
        SCAN_LAST,
        RESPOND
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == IDLE);
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (s_valid && ready_reg)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = DECODE;
                end
            end
            DECODE:
            begin
                ctl.status_load = 1'b1;
                unique case (sts.cmd)
                    CMD_INSERT:
                    begin
                        ctl.do_insert = sts.in_range && !sts.present;
                        state_next    = RESPOND;
                    end
                    CMD_INCREASE:
                    begin
                        ctl.rd_entry = sts.present;
                        state_next   = sts.present ? INC_WAIT : RESPOND;
                    end
                    CMD_REMOVE:
                    begin
                        ctl.do_remove = sts.present;
                        state_next    = RESPOND;
                    end
                    CMD_QUERY:
                    begin
                        ctl.scan_clear = 1'b1;
                        state_next     = SCAN;
                    end
                    default:
                    begin
                        state_next = RESPOND;
                    end
                endcase
            end
            INC_WAIT:
            begin
                ctl.do_inc_wr = 1'b1;
                state_next    = RESPOND;
            end
            SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = SCAN_LAST;
                end
            end
            SCAN_LAST:
            begin
                // last read word is compared in this cycle
                state_next = RESPOND;
            end
            RESPOND:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    assign s_ready = ready_reg;

endmodule

@@ rtl/ipq_dp.sv @@
module ipq_dp #(
    parameter int ENTRY_COUNT = ipq_pkg::ENTRY_COUNT_DEF,
    parameter int LEVEL_BITS  = ipq_pkg::LEVEL_BITS_DEF,
    parameter int STAMP_BITS  = ipq_pkg::STAMP_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ipq_pkg::ctrl_cmd_t            ctl,
    output ipq_pkg::ctrl_sts_t            sts,
    input  logic [ipq_pkg::CMD_W-1:0]     in_command,
    input  logic [ipq_pkg::ID_W-1:0]      in_entry_id,
    input  logic [ipq_pkg::AMT_W-1:0]     in_amount,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ipq_pkg::STATUS_W-1:0]  out_status,
    output logic [ipq_pkg::ID_W-1:0]      out_top_id,
    output logic [ipq_pkg::AMT_W-1:0]     out_top_level
);

    import ipq_pkg::*;

    localparam int SLOTS  = (ENTRY_COUNT < MAX_SLOTS) ? ENTRY_COUNT : MAX_SLOTS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int WORD_W = LEVEL_BITS + STAMP_BITS;
    localparam int SUM_W  = ((LEVEL_BITS > AMT_W) ? LEVEL_BITS : AMT_W) + 1;

    localparam logic [SUM_W-1:0]      LEVEL_MAX_W = SUM_W'({LEVEL_BITS{1'b1}});
    localparam logic [STAMP_BITS-1:0] STAMP_MAX   = {STAMP_BITS{1'b1}};

    function automatic logic [LEVEL_BITS-1:0] sat_level(input logic [SUM_W-1:0] v);
        logic [LEVEL_BITS-1:0] r;
        r = (v > LEVEL_MAX_W) ? LEVEL_MAX_W[LEVEL_BITS-1:0] : v[LEVEL_BITS-1:0];
        return r;
    endfunction

    cmd_t               cmd_reg;
    logic [ID_W-1:0]    id_reg;
    logic [AMT_W-1:0]   amt_reg;
    status_t            status_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic [STAMP_BITS-1:0] stamp_reg;

    logic [SLOT_W-1:0]  scan_cnt_reg;
    logic               rd_pend_reg;
    logic               cmp_vld_reg;
    logic [SLOT_W-1:0]  cmp_idx_reg;
    logic               found_reg;
    logic [SLOT_W-1:0]  best_id_reg;
    logic [LEVEL_BITS-1:0] best_level_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [AMT_W-1:0]   out_level_reg;

    logic [SLOT_W-1:0]  idx;
    logic               in_range;
    logic               present;
    logic               out_free;
    status_t            status_next;

    logic               ram_we;
    logic [WORD_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic [LEVEL_BITS-1:0] rd_level;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [LEVEL_BITS-1:0] ins_level;
    logic [LEVEL_BITS-1:0] inc_level;
    logic               take;
    logic               query_hit;
    logic [SUM_W-1:0]   best_level_w;

    assign idx      = id_reg[SLOT_W-1:0];
    assign in_range = 32'(id_reg) < 32'(ENTRY_COUNT);
    assign present  = in_range && valid_reg[idx];
    assign out_free = !out_valid_reg || out_ready;

    assign sts.cmd       = cmd_reg;
    assign sts.in_range  = in_range;
    assign sts.present   = present;
    assign sts.scan_last = (scan_cnt_reg == SLOT_W'(SLOTS - 1));
    assign sts.out_free  = out_free;

    always_comb
    begin
        unique case (cmd_reg)
            CMD_INSERT:   status_next = !in_range ? ST_ABSENT : (present ? ST_PRESENT : ST_OK);
            CMD_INCREASE: status_next = present ? ST_OK : ST_ABSENT;
            CMD_REMOVE:   status_next = present ? ST_OK : ST_ABSENT;
            CMD_QUERY:    status_next = ST_OK;
            default:      status_next = ST_OK;
        endcase
    end

    assign rd_level  = ram_rdata[LEVEL_BITS-1:0];
    assign rd_stamp  = ram_rdata[LEVEL_BITS +: STAMP_BITS];
    assign ins_level = sat_level(SUM_W'(amt_reg));
    assign inc_level = sat_level(SUM_W'(rd_level) + SUM_W'(amt_reg));

    // increase keeps the stamp that came back from the read
    assign ram_we    = ctl.do_insert || ctl.do_inc_wr;
    assign ram_wdata = ctl.do_inc_wr ? {rd_stamp, inc_level} : {stamp_reg, ins_level};
    assign ram_re    = ctl.rd_entry || ctl.scan_step;
    assign ram_raddr = ctl.scan_step ? scan_cnt_reg : idx;

    ipq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // ascending scan, so equal level and stamp keeps the lower id
    assign take = rd_pend_reg && cmp_vld_reg &&
                  (!found_reg || (rd_level > best_level_reg) ||
                   ((rd_level == best_level_reg) && (rd_stamp < best_stamp_reg)));

    assign query_hit    = (cmd_reg == CMD_QUERY) && found_reg;
    assign best_level_w = SUM_W'(best_level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            stamp_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_cnt_reg  <= '0;
        end
        else
        begin
            if (ctl.do_insert)
            begin
                valid_reg[idx] <= 1'b1;
                if (stamp_reg != STAMP_MAX)
                begin
                    stamp_reg <= stamp_reg + 1'b1;
                end
            end
            else if (ctl.do_remove)
            begin
                valid_reg[idx] <= 1'b0;
            end

            rd_pend_reg <= ctl.scan_step;

            if (ctl.scan_clear)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (ctl.scan_step)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg <= cmd_t'(in_command);
            id_reg  <= in_entry_id;
            amt_reg <= in_amount;
        end
        if (ctl.status_load)
        begin
            status_reg <= status_next;
        end
        cmp_idx_reg <= scan_cnt_reg;
        cmp_vld_reg <= valid_reg[scan_cnt_reg];
        if (take)
        begin
            best_id_reg    <= cmp_idx_reg;
            best_level_reg <= rd_level;
            best_stamp_reg <= rd_stamp;
        end
        if (ctl.out_load)
        begin
            if (cmd_reg == CMD_QUERY)
            begin
                out_status_reg <= found_reg ? ST_OK : ST_EMPTY;
            end
            else
            begin
                out_status_reg <= status_reg;
            end
            out_id_reg    <= query_hit ? ID_W'(best_id_reg) : '0;
            out_level_reg <= query_hit ? best_level_w[AMT_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_top_id    = out_id_reg;
    assign out_top_level = out_level_reg;

`ifndef SYNTH
    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_insert |=> valid_reg[$past(idx)])
        else $error("inserted entry not marked present");

    a_stamp_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (stamp_reg >= $past(stamp_reg)))
        else $error("arrival stamp went backwards");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> out_free)
        else $error("result loaded over an untaken one");

    a_scan_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (cmd_reg == CMD_QUERY))
        else $error("scan compare outside a query");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_step |-> !ram_we && !ctl.do_remove)
        else $error("store changed during a scan");
`endif

endmodule

@@ rtl/indexed_priority_queue_fifo_ties.sv @@
// Indexed max-priority queue over up to 64 entries, one result per request.
// A request carries a command (insert, increase level, remove, query top) in
// s_axis_tuser and the entry id and amount in s_axis_tdata; the result gives a
// status in m_axis_tuser and, for a successful query, the top id and level in
// m_axis_tdata. Levels saturate, ties go to the earliest insert and then to the
// lower id. Levels and stamps sit in a single-port-write, registered-read RAM,
// so a query reads every slot through one comparator, and its time from
// acceptance to the next ready is set by the RAM scan. Increase reads the
// entry, then writes it back; insert and remove need no read.
// A request is taken while the previous result is still held; the block only
// waits in its final cycle if that earlier result has not yet been taken.
module indexed_priority_queue_fifo_ties #(
    parameter int ENTRY_COUNT = ipq_pkg::ENTRY_COUNT_DEF,
    parameter int LEVEL_BITS  = ipq_pkg::LEVEL_BITS_DEF,
    parameter int STAMP_BITS  = ipq_pkg::STAMP_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // entry_id[5:0], amount[21:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // top_id[5:0], top_level[21:6], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    import ipq_pkg::*;

    ctrl_cmd_t            ctl;
    ctrl_sts_t            sts;
    logic [ID_W-1:0]      top_id;
    logic [AMT_W-1:0]     top_level;
    logic [STATUS_W-1:0]  status;

    ipq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .sts    (sts),
        .ctl    (ctl)
    );

    ipq_dp #(
        .ENTRY_COUNT(ENTRY_COUNT),
        .LEVEL_BITS (LEVEL_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .in_command   (s_axis_tuser[CMD_W-1:0]),
        .in_entry_id  (s_axis_tdata[ID_W-1:0]),
        .in_amount    (s_axis_tdata[ID_W +: AMT_W]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_status   (status),
        .out_top_id   (top_id),
        .out_top_level(top_level)
    );

    assign m_axis_tdata = {2'b00, top_level, top_id};
    assign m_axis_tuser = status;

endmodule

@@ bench/tb_indexed_priority_queue_fifo_ties.sv @@
`timescale 1ns / 1ps

module tb_indexed_priority_queue_fifo_ties;

    import ipq_pkg::*;

    typedef struct {
        status_t     status;
        logic [5:0]  top_id;
        logic [15:0] top_level;
    } ipq_result_t;

    typedef enum int {
        MIX_FILL,
        MIX_CHURN
    } mix_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // shadow copy of the queue contents
    bit          q_live    [64];
    logic [15:0] q_level   [64];
    logic [31:0] q_arrival [64];
    logic [31:0] arrival_count = '0;

    ipq_result_t pending_results [$];
    int          mismatch_count = 0;
    bit          idle_on = 1'b0;

    indexed_priority_queue_fifo_ties u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic ipq_result_t predict_result(cmd_t c, logic [5:0] id, logic [15:0] amt);
        ipq_result_t r;
        logic [16:0] sum;
        int          best;
        r.status    = ST_OK;
        r.top_id    = '0;
        r.top_level = '0;
        case (c)
            CMD_INSERT:
            begin
                if (q_live[id])
                    r.status = ST_PRESENT;
                else
                begin
                    q_live[id]    = 1'b1;
                    q_level[id]   = amt;
                    q_arrival[id] = arrival_count;
                    if (arrival_count != '1)
                        arrival_count = arrival_count + 1;
                end
            end
            CMD_INCREASE:
            begin
                if (!q_live[id])
                    r.status = ST_ABSENT;
                else
                begin
                    sum         = {1'b0, q_level[id]} + {1'b0, amt};
                    q_level[id] = sum[16] ? 16'hFFFF : sum[15:0];
                end
            end
            CMD_REMOVE:
            begin
                if (!q_live[id])
                    r.status = ST_ABSENT;
                else
                    q_live[id] = 1'b0;
            end
            default:
            begin
                best = -1;
                // strict compares keep the lower id on a full tie
                for (int i = 0; i < 64; i++)
                begin
                    if (q_live[i] && (best < 0 || q_level[i] > q_level[best] ||
                        (q_level[i] == q_level[best] && q_arrival[i] < q_arrival[best])))
                        best = i;
                end
                if (best < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.top_id    = best[5:0];
                    r.top_level = q_level[best];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_request(cmd_t c, logic [5:0] id, logic [15:0] amt);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, amt, id};
        s_axis_tuser  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_result(c, id, amt));
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [5:0] pick_id();
        int live_ids [$];
        for (int i = 0; i < 64; i++)
            if (q_live[i])
                live_ids.push_back(i);
        if (live_ids.size() != 0 && $urandom_range(0, 1) == 0)
            return 6'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [15:0] pick_amount();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic cmd_t pick_cmd(mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (mix == MIX_FILL)
        begin
            if (roll < 50) return CMD_INSERT;
            if (roll < 65) return CMD_INCREASE;
            if (roll < 75) return CMD_REMOVE;
            return CMD_QUERY;
        end
        if (roll < 25) return CMD_INSERT;
        if (roll < 50) return CMD_INCREASE;
        if (roll < 75) return CMD_REMOVE;
        return CMD_QUERY;
    endfunction

    task automatic test_directed_cases();
        idle_on = 1'b1;
        send_request(CMD_QUERY,    6'd0,  16'h0000);  // empty queue
        send_request(CMD_INCREASE, 6'd5,  16'h0007);  // absent entry
        send_request(CMD_REMOVE,   6'd5,  16'hFFFF);
        send_request(CMD_INSERT,   6'd0,  16'h0001);
        send_request(CMD_INSERT,   6'd63, 16'hFFFF);
        send_request(CMD_INSERT,   6'd63, 16'h0001);  // already present
        send_request(CMD_QUERY,    6'd17, 16'h1234);
        send_request(CMD_INCREASE, 6'd0,  16'hFFFF);  // saturates, ties with 63
        send_request(CMD_QUERY,    6'd0,  16'h0000);
        send_request(CMD_INCREASE, 6'd63, 16'h0000);
        send_request(CMD_REMOVE,   6'd0,  16'h0000);
        send_request(CMD_QUERY,    6'd0,  16'h0000);
        send_request(CMD_REMOVE,   6'd63, 16'h0000);
        send_request(CMD_QUERY,    6'd63, 16'hFFFF);
        send_request(CMD_INSERT,   6'd42, 16'h5555);
        send_request(CMD_INSERT,   6'd21, 16'hAAAA);
        send_request(CMD_INSERT,   6'd10, 16'hAAAA);  // equal level, later stamp
        send_request(CMD_QUERY,    6'd0,  16'h0000);
        send_request(CMD_INCREASE, 6'd10, 16'h0001);
        send_request(CMD_QUERY,    6'd0,  16'h0000);
        send_request(CMD_INSERT,   6'd1,  16'h0000);
        send_request(CMD_REMOVE,   6'd10, 16'h0000);
        send_request(CMD_REMOVE,   6'd21, 16'h0000);
        send_request(CMD_REMOVE,   6'd42, 16'h0000);
        send_request(CMD_QUERY,    6'd0,  16'h0000);
    endtask

    task automatic test_pause_until_drained();
        idle_on = 1'b1;
        send_request(CMD_INSERT, 6'd33, 16'h8001);
        send_request(CMD_QUERY,  6'd0,  16'h0000);
        hold_until_drained();
        send_request(CMD_INCREASE, 6'd33, 16'h7FFF);
        send_request(CMD_QUERY,    6'd0,  16'h0000);
        send_request(CMD_REMOVE,   6'd33, 16'h0000);
    endtask

    task automatic test_random_traffic(int count, mix_t mix, bit with_idle);
        cmd_t        c;
        logic [5:0]  id;
        logic [15:0] amt;
        idle_on = with_idle;
        repeat (count)
        begin
            c   = pick_cmd(mix);
            id  = pick_id();
            amt = pick_amount();
            send_request(c, id, amt);
        end
    endtask

    // result side back-pressure
    initial
    begin
        int n;
        @(posedge rst_n);
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        ipq_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tuser, want.status));
                if (m_axis_tdata[5:0] !== want.top_id)
                    report_mismatch($sformatf("top_id got %0d want %0d",
                                              m_axis_tdata[5:0], want.top_id));
                if (m_axis_tdata[21:6] !== want.top_level)
                    report_mismatch($sformatf("top_level got %h want %h",
                                              m_axis_tdata[21:6], want.top_level));
            end
        end
    end

    initial
    begin
        #8ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < 64; i++)
        begin
            q_live[i]    = 1'b0;
            q_level[i]   = '0;
            q_arrival[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_pause_until_drained();
        test_random_traffic(500, MIX_FILL, 1'b1);
        test_random_traffic(500, MIX_CHURN, 1'b1);
        test_random_traffic(525, MIX_CHURN, 1'b0);

        hold_until_drained();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
